// ===== rtl/wsa_pkg.sv =====
package wsa_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;
  localparam int INTERVAL_W = 22;
  localparam int VAL_W      = 16;
  localparam int MIN_W      = 16;
  localparam int CNT_OUT_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_INTERVAL = 3'd0,
    REG_FIRST_WINDOW    = 3'd1,
    REG_MIN_FIRST       = 3'd2,
    REG_MIN_STEADY      = 3'd3,
    REG_TEMP_HIGH       = 3'd4,
    REG_TEMP_LOW        = 3'd5,
    REG_HUMI_HIGH       = 3'd6,
    REG_HUMI_LOW        = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_WAIT,
    S_FLOOR,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] temp_average;
    logic signed [VAL_W-1:0] humi_average;
    logic [CNT_OUT_W-1:0]    sample_count;
    logic                    empty_window;
    logic                    too_few;
    logic                    time_drift;
    logic                    temp_over;
    logic                    temp_under;
    logic                    humi_over;
    logic                    humi_under;
    logic                    was_first;
  } report_t;

endpackage

// ===== rtl/wsa_ifs.sv =====
interface wsa_cfg_if import wsa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface

interface wsa_in_if import wsa_pkg::*; #(
  parameter int STAMP_BITS = 48
) ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [STAMP_BITS-1:0]   stamp_ms;
  logic                    reading_ok;
  logic signed [VAL_W-1:0] temp_value;
  logic signed [VAL_W-1:0] humi_value;

  modport source (output valid, kind, stamp_ms, reading_ok, temp_value, humi_value,
                  input ready);
  modport sink (input valid, kind, stamp_ms, reading_ok, temp_value, humi_value,
                output ready);
endinterface

interface wsa_out_if import wsa_pkg::*; #(
  parameter int STAMP_BITS = 48
) ();
  logic                    valid;
  logic                    ready;
  logic [STAMP_BITS-1:0]   window_end_ms;
  logic signed [VAL_W-1:0] temp_average;
  logic signed [VAL_W-1:0] humi_average;
  logic [CNT_OUT_W-1:0]    sample_count;
  logic                    empty_window;
  logic                    too_few;
  logic                    time_drift;
  logic                    temp_over;
  logic                    temp_under;
  logic                    humi_over;
  logic                    humi_under;
  logic                    was_first;

  modport source (output valid, window_end_ms, temp_average, humi_average, sample_count,
                  empty_window, too_few, time_drift, temp_over, temp_under, humi_over,
                  humi_under, was_first, input ready);
  modport sink (input valid, window_end_ms, temp_average, humi_average, sample_count,
                empty_window, too_few, time_drift, temp_over, temp_under, humi_over,
                humi_under, was_first, output ready);
endinterface

// ===== rtl/windowed_sensor_average_alarm_top.sv =====
// Two-channel window averager with alarm flags. A start beat sets the first window end to
// its stamp plus first_window_ms; sample beats with reading_ok add to the sums and count, and
// a sample whose stamp reaches the window end produces one report, after which the next end
// is the next multiple of the output interval past that stamp. A start beat or a sample that
// closes no window goes through the update state back to idle before the next input beat.
// A closing sample goes on through the start, wait, floor and emit states, its report
// registered as the state leaves emit for idle; the wait lasts until the longest of the
// bit-serial dividers is done, the one that reduces the stamp modulo the interval and the
// two average dividers running alongside it. A report still waiting in the output register
// holds a closing sample in its last step until the register is taken; the input is taken
// again while that report waits. Configuration writes are accepted every cycle.
module windowed_sensor_average_alarm_top import wsa_pkg::*; #(
  parameter int DRIFT_TOLERANCE_MS = 100,
  parameter int STAMP_BITS         = 48,
  parameter int COUNT_BITS         = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsa_cfg_if.sink    cfg_i,
  wsa_in_if.sink     in_i,
  wsa_out_if.source  out_o
);

  localparam int AccW    = VAL_W + COUNT_BITS;
  localparam int CntExtW = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

  state_e state_q, state_d;

  // configuration
  logic [INTERVAL_W-1:0]   interval_q;
  logic [INTERVAL_W-1:0]   first_win_q;
  logic [MIN_W-1:0]        min_first_q;
  logic [MIN_W-1:0]        min_steady_q;
  logic signed [VAL_W-1:0] t_hi_q, t_lo_q, h_hi_q, h_lo_q;

  // captured beat
  logic                    kind_q;
  logic [STAMP_BITS-1:0]   stamp_q;
  logic                    ok_q;
  logic signed [VAL_W-1:0] tv_q, hv_q;

  // window state
  logic [STAMP_BITS-1:0]  first_bnd_q, next_bnd_q, last_good_q;
  logic                   first_done_q;
  logic signed [AccW-1:0] t_acc_q, h_acc_q;
  logic [COUNT_BITS-1:0]  cnt_q;

  // close work
  logic [STAMP_BITS-1:0] bound_q, dist_q, floor_q;
  logic                  was_first_q;

  // result
  logic                  out_valid_q;
  logic [STAMP_BITS-1:0] out_end_q;
  report_t               out_rep_q, rep_c;

  logic                  in_acc, div_start, emit;
  logic [STAMP_BITS-1:0] bound_c;
  logic [INTERVAL_W-1:0] interval_eff;
  logic [AccW-1:0]       t_mag, h_mag, t_quot, h_quot, t_sq, h_sq;
  logic                  t_busy, h_busy, s_busy;
  logic [STAMP_BITS-1:0] s_quot;
  logic [INTERVAL_W-1:0] s_rem;
  logic [COUNT_BITS-1:0] t_rem, h_rem;
  logic [CntExtW-1:0]    cnt_ext, min_ext;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= INTERVAL_W'(1000);
      first_win_q  <= INTERVAL_W'(1000);
      min_first_q  <= '0;
      min_steady_q <= '0;
      t_hi_q       <= 16'sh7fff;
      t_lo_q       <= 16'sh8000;
      h_hi_q       <= 16'sh7fff;
      h_lo_q       <= 16'sh8000;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.idx))
        REG_OUTPUT_INTERVAL: interval_q   <= cfg_i.wdata;
        REG_FIRST_WINDOW:    first_win_q  <= cfg_i.wdata;
        REG_MIN_FIRST:       min_first_q  <= cfg_i.wdata[MIN_W-1:0];
        REG_MIN_STEADY:      min_steady_q <= cfg_i.wdata[MIN_W-1:0];
        REG_TEMP_HIGH:       t_hi_q       <= cfg_i.wdata[VAL_W-1:0];
        REG_TEMP_LOW:        t_lo_q       <= cfg_i.wdata[VAL_W-1:0];
        REG_HUMI_HIGH:       h_hi_q       <= cfg_i.wdata[VAL_W-1:0];
        REG_HUMI_LOW:        h_lo_q       <= cfg_i.wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign in_acc       = in_i.valid && in_i.ready;
  assign bound_c      = first_done_q ? next_bnd_q : first_bnd_q;
  assign interval_eff = (interval_q == '0) ? INTERVAL_W'(1) : interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    emit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (kind_q == KIND_START || stamp_q < bound_c) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_START;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (!t_busy && !h_busy && !s_busy) begin
          state_d = S_FLOOR;
        end
      end
      S_FLOOR: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= in_i.kind;
      stamp_q <= in_i.stamp_ms;
      ok_q    <= in_i.reading_ok;
      tv_q    <= in_i.temp_value;
      hv_q    <= in_i.humi_value;
    end
    if (state_q == S_UPDATE) begin
      bound_q     <= bound_c;
      was_first_q <= !first_done_q;
    end
    if (state_q == S_START) begin
      dist_q <= (last_good_q >= bound_q) ? last_good_q - bound_q : bound_q - last_good_q;
    end
    if (state_q == S_FLOOR) begin
      floor_q <= stamp_q - STAMP_BITS'(s_rem);
    end
    if (emit) begin
      out_end_q <= bound_q;
      out_rep_q <= rep_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_bnd_q  <= '0;
      next_bnd_q   <= '0;
      first_done_q <= 1'b0;
      t_acc_q      <= '0;
      h_acc_q      <= '0;
      cnt_q        <= '0;
      last_good_q  <= '0;
    end else if (state_q == S_UPDATE) begin
      if (kind_q == KIND_START) begin
        first_bnd_q  <= stamp_q + STAMP_BITS'(first_win_q);
        first_done_q <= 1'b0;
        t_acc_q      <= '0;
        h_acc_q      <= '0;
        cnt_q        <= '0;
        last_good_q  <= '0;
      end else if (ok_q) begin
        if (cnt_q != '1) begin
          t_acc_q <= t_acc_q + AccW'(tv_q);
          h_acc_q <= h_acc_q + AccW'(hv_q);
          cnt_q   <= cnt_q + COUNT_BITS'(1);
        end
        last_good_q <= stamp_q;
      end
    end else if (emit) begin
      next_bnd_q   <= floor_q + STAMP_BITS'(interval_eff);
      first_done_q <= 1'b1;
      t_acc_q      <= '0;
      h_acc_q      <= '0;
      cnt_q        <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign t_mag = t_acc_q[AccW-1] ? AccW'(-t_acc_q) : AccW'(t_acc_q);
  assign h_mag = h_acc_q[AccW-1] ? AccW'(-h_acc_q) : AccW'(h_acc_q);

  wsa_serdiv #(.DVD_W(AccW), .DVS_W(COUNT_BITS)) u_tdiv (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(t_mag), .divisor_i(cnt_q),
    .busy_o(t_busy), .quot_o(t_quot), .rem_o(t_rem)
  );

  wsa_serdiv #(.DVD_W(AccW), .DVS_W(COUNT_BITS)) u_hdiv (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(h_mag), .divisor_i(cnt_q),
    .busy_o(h_busy), .quot_o(h_quot), .rem_o(h_rem)
  );

  wsa_serdiv #(.DVD_W(STAMP_BITS), .DVS_W(INTERVAL_W)) u_sdiv (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(stamp_q), .divisor_i(interval_eff),
    .busy_o(s_busy), .quot_o(s_quot), .rem_o(s_rem)
  );

  // truncation toward zero: divide magnitudes, restore sign
  assign t_sq    = t_acc_q[AccW-1] ? -t_quot : t_quot;
  assign h_sq    = h_acc_q[AccW-1] ? -h_quot : h_quot;
  assign cnt_ext = CntExtW'(cnt_q);
  assign min_ext = CntExtW'(was_first_q ? min_first_q : min_steady_q);

  always_comb begin
    rep_c              = '0;
    rep_c.was_first    = was_first_q;
    rep_c.sample_count = (cnt_ext > CntExtW'({CNT_OUT_W{1'b1}})) ? {CNT_OUT_W{1'b1}}
                                                                  : cnt_ext[CNT_OUT_W-1:0];
    if (cnt_q == '0) begin
      rep_c.empty_window = 1'b1;
    end else begin
      rep_c.temp_average = t_sq[VAL_W-1:0];
      rep_c.humi_average = h_sq[VAL_W-1:0];
      rep_c.too_few      = cnt_ext < min_ext;
      rep_c.time_drift   = dist_q > STAMP_BITS'(DRIFT_TOLERANCE_MS);
      rep_c.temp_over    = $signed(t_sq[VAL_W-1:0]) > t_hi_q;
      rep_c.temp_under   = $signed(t_sq[VAL_W-1:0]) < t_lo_q;
      rep_c.humi_over    = $signed(h_sq[VAL_W-1:0]) > h_hi_q;
      rep_c.humi_under   = $signed(h_sq[VAL_W-1:0]) < h_lo_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.window_end_ms = out_end_q;
  assign out_o.temp_average  = out_rep_q.temp_average;
  assign out_o.humi_average  = out_rep_q.humi_average;
  assign out_o.sample_count  = out_rep_q.sample_count;
  assign out_o.empty_window  = out_rep_q.empty_window;
  assign out_o.too_few       = out_rep_q.too_few;
  assign out_o.time_drift    = out_rep_q.time_drift;
  assign out_o.temp_over     = out_rep_q.temp_over;
  assign out_o.temp_under    = out_rep_q.temp_under;
  assign out_o.humi_over     = out_rep_q.humi_over;
  assign out_o.humi_under    = out_rep_q.humi_under;
  assign out_o.was_first     = out_rep_q.was_first;

`ifndef SYNTHESIS
  a_emit_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> !t_busy && !h_busy && !s_busy)
    else $error("report formed while a divider is busy");

  a_empty_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> t_acc_q == '0 && h_acc_q == '0)
    else $error("sums nonzero with empty window");

  a_beat_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("report beat raised outside emit");
`endif

endmodule

// ===== rtl/wsa_serdiv.sv =====
module wsa_serdiv import wsa_pkg::*; #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quot_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int CntW = $clog2(DVD_W + 1);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], fits};
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

`ifndef SYNTHESIS
  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0)
    else $error("divider idle with nonzero step count");

  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && dvs_q != '0 |-> rem_q < dvs_q)
    else $error("partial remainder not below divisor");

  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_q |=> busy_q && cnt_q == CntW'(DVD_W))
    else $error("divider did not start");
`endif

endmodule
